[sv/ceo_pkg.sv]
// shared types and constants of the exchange clock offset estimator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ceo_pkg;

	localparam int NUM_EXCHANGES = 16;
	localparam int MAX_WINDOW    = 16;
	localparam int EX_W          = 4;
	localparam int RING_W        = 4;
	localparam int ADDR_W        = EX_W + RING_W;
	localparam int MEM_DEPTH     = NUM_EXCHANGES * MAX_WINDOW;

	localparam logic [16:0] WEIGHT_ONE   = 17'd65536;
	localparam logic [16:0] WEIGHT_FLOOR = 17'd6554;
	// ceil(2^67 / 1e9) split at bit 19
	localparam logic [18:0] W_RECIP_LO   = 19'd512078;
	localparam logic [18:0] W_RECIP_HI   = 19'd281474;
	localparam logic [47:0] POS_LIMIT    = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] NEG_LIMIT    = 48'h8000_0000_0000;
	localparam logic [4:0]  WINDOW_MAX   = 5'd16;
	localparam logic [4:0]  WINDOW_RESET = 5'd16;

	localparam logic [0:0]  REG_WINDOW_LEN = 1'b0;

	typedef struct packed {
		logic [EX_W-1:0]   ex;
		logic [RING_W-1:0] slot;
		logic [47:0]       off;
		logic [16:0]       w;
		logic [4:0]        cnt;
		logic              first;
		logic              sat;
	} item_t;

endpackage
`default_nettype wire

[sv/ceo_front.sv]
// front end: takes sample beats, forms offset and weight, updates ring bookkeeping
// depends on ceo_pkg
`timescale 1ns / 1ps
`default_nettype none
module ceo_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [3:0]                exchange_id,
	input  wire logic [62:0]               venue_ts,
	input  wire logic [62:0]               host_ts,
	input  wire logic [39:0]               rtt_ns,
	input  wire logic [4:0]                window_len,
	input  wire logic                      full,
	output logic                           push,
	output ceo_pkg::item_t                 item
);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_MUL  = 2'd1;
	localparam logic [1:0] F_PUSH = 2'd2;

	logic [1:0]  state_q;
	logic [ceo_pkg::EX_W-1:0] ex_q;
	logic [62:0] loc_q;
	logic [63:0] sub_q;
	logic [39:0] rtt_q;
	logic [48:0] plo_q;
	logic [48:0] phi_q;

	logic                       seen_q [ceo_pkg::NUM_EXCHANGES];
	logic [4:0]                 count_q [ceo_pkg::NUM_EXCHANGES];
	logic [ceo_pkg::RING_W-1:0] head_q [ceo_pkg::NUM_EXCHANGES];

	logic [67:0] wsum;
	logic [16:0] wq;
	logic [64:0] diff;
	logic        neg, sat;
	logic [47:0] off;
	logic [16:0] wraw, w;
	logic [4:0]  win, cnt_inc, cnt;
	logic        first;

	assign in_ready = (state_q == F_IDLE);
	// weight quotient by reciprocal of 1e9, shifted down by 51
	assign wsum = {phi_q, 19'd0} + {19'd0, plo_q};
	assign wq   = wsum[67:51];

	always_comb begin
		diff = {2'b00, loc_q} - {1'b0, sub_q};
		neg  = diff[64];
		if (neg) begin
			sat = (diff[64:47] != {18{1'b1}});
		end else begin
			sat = (diff[63:47] != 17'd0);
		end
		if (sat) begin
			off = neg ? ceo_pkg::NEG_LIMIT : ceo_pkg::POS_LIMIT;
		end else begin
			off = diff[47:0];
		end
		wraw = wq[16] ? 17'd0 : (ceo_pkg::WEIGHT_ONE - wq);
		if ((rtt_q[39:30] != 10'd0) || (wraw < ceo_pkg::WEIGHT_FLOOR)) begin
			w = ceo_pkg::WEIGHT_FLOOR;
		end else begin
			w = wraw;
		end
		if (window_len == 5'd0) begin
			win = 5'd1;
		end else if (window_len > ceo_pkg::WINDOW_MAX) begin
			win = ceo_pkg::WINDOW_MAX;
		end else begin
			win = window_len;
		end
		first   = !seen_q[ex_q];
		cnt_inc = count_q[ex_q] + 5'd1;
		if (first) begin
			cnt = 5'd1;
		end else if (cnt_inc > win) begin
			cnt = win;
		end else begin
			cnt = cnt_inc;
		end
		item.ex    = ex_q;
		item.slot  = head_q[ex_q];
		item.off   = off;
		item.w     = w;
		item.cnt   = cnt;
		item.first = first;
		item.sat   = sat;
	end

	assign push = (state_q == F_PUSH) && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			for (int i = 0; i < ceo_pkg::NUM_EXCHANGES; i++) begin
				seen_q[i]  <= 1'b0;
				count_q[i] <= 5'd0;
				head_q[i]  <= '0;
			end
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						state_q <= F_MUL;
					end
				end
				F_MUL: begin
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!full) begin
						seen_q[ex_q]  <= 1'b1;
						count_q[ex_q] <= cnt;
						head_q[ex_q]  <= head_q[ex_q] + 1'b1;
						state_q       <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ex_q   <= exchange_id;
			loc_q  <= host_ts;
			rtt_q  <= rtt_ns;
			sub_q  <= {1'b0, venue_ts} + {25'd0, rtt_ns[39:1]};
		end else if (state_q == F_MUL) begin
			plo_q <= {19'd0, rtt_q[29:0]} * {30'd0, ceo_pkg::W_RECIP_LO};
			phi_q <= {19'd0, rtt_q[29:0]} * {30'd0, ceo_pkg::W_RECIP_HI};
		end
	end

endmodule
`default_nettype wire

[sv/ceo_fifo.sv]
// two-entry queue of sample items between front and back
// depends on ceo_pkg
`timescale 1ns / 1ps
`default_nettype none
module ceo_fifo (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire ceo_pkg::item_t din,
	output logic        full,
	input  wire logic   pop,
	output logic        not_empty,
	output ceo_pkg::item_t dout
);

	ceo_pkg::item_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] fill_q;

	assign full      = (fill_q == 2'd2);
	assign not_empty = (fill_q != 2'd0);
	assign dout      = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= din;
		end
	end

endmodule
`default_nettype wire

[sv/ceo_back.sv]
// back end: sample ring memory, window walk, weighted mean by serial division
// depends on ceo_pkg
`timescale 1ns / 1ps
`default_nettype none
module ceo_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        not_empty,
	input  wire ceo_pkg::item_t din,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [47:0]      est_offset,
	output logic [16:0]      est_weight,
	output logic [4:0]       samples_used,
	output logic             first_sample,
	output logic             offset_saturated
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_ACC  = 3'd3;
	localparam logic [2:0] S_PREP = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0]  state_q;
	ceo_pkg::item_t it_q;
	logic [64:0] mem_q [ceo_pkg::MEM_DEPTH];
	logic [64:0] rd_q;
	logic [ceo_pkg::ADDR_W-1:0] raddr;
	logic [ceo_pkg::RING_W-1:0] k_q;
	logic [64:0] prod_q;
	logic        pneg_q;
	logic [69:0] acc_q;
	logic [20:0] total_q;
	logic [20:0] rem_q;
	logic [47:0] nq_q;
	logic [5:0]  dcnt_q;
	logic [4:0]  crem_q;
	logic [20:0] cq_q;
	logic        rneg_q;

	logic [47:0] rd_off, rd_mag;
	logic [69:0] num;
	logic [21:0] dcur;
	logic        dge;
	logic [5:0]  ccur;
	logic        cge;

	assign pop   = (state_q == S_IDLE) && not_empty;
	assign raddr = {it_q.ex, it_q.slot - k_q};
	assign rd_off = rd_q[64:17];
	assign rd_mag = rd_off[47] ? (48'd0 - rd_off) : rd_off;
	assign num    = acc_q[69] ? (70'd0 - acc_q) : acc_q;
	assign dcur   = {rem_q, nq_q[47]};
	assign dge    = (dcur >= {1'b0, total_q});
	assign ccur   = {crem_q, cq_q[20]};
	assign cge    = (ccur >= {1'b0, it_q.cnt});
	assign out_valid = (state_q == S_OUT);

	always_ff @(posedge clk) begin
		if (pop) begin
			mem_q[{din.ex, din.slot}] <= {din.off, din.w};
		end
		rd_q <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
			dcnt_q  <= 6'd0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (not_empty) begin
						state_q <= S_RD;
						k_q     <= '0;
					end
				end
				S_RD:  state_q <= S_MUL;
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					if ({1'b0, k_q} == it_q.cnt - 5'd1) begin
						state_q <= S_PREP;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_PREP: begin
					state_q <= S_DIV;
					dcnt_q  <= 6'd0;
				end
				S_DIV: begin
					dcnt_q <= dcnt_q + 6'd1;
					if (dcnt_q == 6'd47) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				it_q    <= din;
				acc_q   <= 70'd0;
				total_q <= 21'd0;
			end
			S_MUL: begin
				prod_q  <= rd_mag * rd_q[16:0];
				pneg_q  <= rd_off[47];
				total_q <= total_q + {4'd0, rd_q[16:0]};
			end
			S_ACC: begin
				acc_q <= pneg_q ? (acc_q - {5'd0, prod_q}) : (acc_q + {5'd0, prod_q});
			end
			S_PREP: begin
				rneg_q <= acc_q[69];
				rem_q  <= {1'b0, num[67:48]};
				nq_q   <= num[47:0];
				crem_q <= 5'd0;
				cq_q   <= total_q;
			end
			S_DIV: begin
				rem_q <= dge ? 21'(dcur - {1'b0, total_q}) : dcur[20:0];
				nq_q  <= {nq_q[46:0], dge};
				if (dcnt_q < 6'd21) begin
					crem_q <= cge ? 5'(ccur - {1'b0, it_q.cnt}) : ccur[4:0];
					cq_q   <= {cq_q[19:0], cge};
				end
				if (dcnt_q == 6'd47) begin
					est_offset <= rneg_q ? (48'd0 - {nq_q[46:0], dge})
						: {nq_q[46:0], dge};
					est_weight        <= cq_q[16:0];
					samples_used      <= it_q.cnt;
					first_sample      <= it_q.first;
					offset_saturated  <= it_q.sat;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTH
	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (samples_used != 5'd0) && (samples_used <= ceo_pkg::WINDOW_MAX))
		else $error("samples_used out of range");
	a_total_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (total_q >= {4'd0, ceo_pkg::WEIGHT_FLOOR}))
		else $error("weight total below floor during divide");
	a_conf_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (est_weight <= ceo_pkg::WEIGHT_ONE))
		else $error("confidence above one");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> !pop)
		else $error("second pop while busy");
`endif

endmodule
`default_nettype wire

[sv/exchange_clock_offset_estimator.sv]
// top level: apb register, front end, item queue and back end
// the front takes a new beat only in its idle state, so it holds one beat at a time until
// it is pushed; the back pops no new item until its result is accepted and is the slower
// side, so it sets the sustained rate for the whole path; a two-entry queue between
// them lets the front run ahead and either side stall on its own
// reset clears exchange bookkeeping and window_len (16); the sample ring needs no clearing
`timescale 1ns / 1ps
`default_nettype none
module exchange_clock_offset_estimator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [3:0]  exchange_id,
	input  wire logic [62:0] venue_ts,
	input  wire logic [62:0] host_ts,
	input  wire logic [39:0] rtt_ns,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic signed [47:0] est_offset,
	output logic [16:0]      est_weight,
	output logic [4:0]       samples_used,
	output logic             first_sample,
	output logic             offset_saturated
);

	logic [4:0] window_len_q;
	logic       push, full, pop, not_empty;
	ceo_pkg::item_t f_item, q_item;
	logic [47:0] off_u;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == ceo_pkg::REG_WINDOW_LEN) ? {27'd0, window_len_q} : 32'd0;
	assign est_offset = off_u;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= ceo_pkg::WINDOW_RESET;
		end else if (psel && penable && pwrite && pready
			&& (paddr[2] == ceo_pkg::REG_WINDOW_LEN)) begin
			window_len_q <= pwdata[4:0];
		end
	end

	ceo_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.exchange_id(exchange_id), .venue_ts(venue_ts),
		.host_ts(host_ts), .rtt_ns(rtt_ns),
		.window_len(window_len_q), .full(full), .push(push), .item(f_item)
	);

	ceo_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .din(f_item), .full(full),
		.pop(pop), .not_empty(not_empty), .dout(q_item)
	);

	ceo_back u_back (
		.clk(clk), .arst_n(arst_n), .not_empty(not_empty), .din(q_item), .pop(pop),
		.out_valid(out_valid), .out_ready(out_ready),
		.est_offset(off_u), .est_weight(est_weight),
		.samples_used(samples_used), .first_sample(first_sample),
		.offset_saturated(offset_saturated)
	);

endmodule
`default_nettype wire

[test/tb_top.sv]
// self-checking testbench of the exchange clock offset estimator
// depends on ceo_pkg and exchange_clock_offset_estimator
`timescale 1ns / 1ps

class offset_scoreboard;
	typedef struct {
		logic [47:0] off;
		logic [16:0] conf;
		logic [4:0]  used;
		logic        first;
		logic        sat;
	} offset_result_t;

	bit [4:0]           window_len;
	bit                 seen [16];
	int unsigned        count [16];
	int unsigned        head [16];
	longint             ring_off [16][16];
	int unsigned        ring_w [16][16];
	offset_result_t     pending [$];
	int                 errors;

	function new();
		window_len = 5'd16;
		errors = 0;
		foreach (seen[i]) begin
			seen[i] = 0;
			count[i] = 0;
			head[i] = 0;
		end
	endfunction

	function int unsigned sample_weight(logic [39:0] rtt);
		logic [63:0] q;
		int unsigned w;
		q = ({24'd0, rtt} * 64'd65536) / 64'd1000000000;
		w = (q >= 64'd65536) ? 0 : 65536 - int'(q);
		return (w < 6554) ? 6554 : w;
	endfunction

	function void note_sample(logic [3:0] ex, logic [62:0] ext, logic [62:0] loc,
			logic [39:0] rtt);
		logic [64:0] sub, mag;
		logic signed [127:0] acc;
		logic [127:0] amag;
		bit neg, sat, rneg;
		longint o;
		int unsigned w, win, cnt, h, slot;
		longint unsigned total;
		offset_result_t r;
		sub = {2'b0, ext} + {26'd0, rtt[39:1]};
		neg = {2'b0, loc} < sub;
		mag = neg ? sub - {2'b0, loc} : {2'b0, loc} - sub;
		sat = 0;
		if (!neg && mag > 65'h7FFF_FFFF_FFFF) begin
			mag = 65'h7FFF_FFFF_FFFF;
			sat = 1;
		end
		if (neg && mag > 65'h8000_0000_0000) begin
			mag = 65'h8000_0000_0000;
			sat = 1;
		end
		o = neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
		w = sample_weight(rtt);
		win = (window_len < 1) ? 1 : ((window_len > 16) ? 16 : window_len);
		h = head[ex];
		ring_off[ex][h] = o;
		ring_w[ex][h] = w;
		head[ex] = (h + 1) % 16;
		cnt = seen[ex] ? ((count[ex] + 1 > win) ? win : count[ex] + 1) : 1;
		r.first = !seen[ex];
		seen[ex] = 1;
		count[ex] = cnt;
		total = w;
		r.off = o[47:0];
		if (!r.first) begin
			acc = 0;
			total = 0;
			for (int k = 0; k < cnt; k++) begin
				slot = (h + 16 - k) % 16;
				acc += 128'(signed'(ring_off[ex][slot])) * 128'(signed'({1'b0, ring_w[ex][slot]}));
				total += ring_w[ex][slot];
			end
			rneg = acc < 0;
			amag = rneg ? -acc : acc;
			amag = amag / 128'(total);
			r.off = rneg ? -amag[47:0] : amag[47:0];
		end
		r.conf = 17'(total / cnt);
		r.used = 5'(cnt);
		r.sat = sat;
		pending.push_back(r);
	endfunction

	function void check_result(logic [47:0] off, logic [16:0] conf, logic [4:0] used,
			logic first, logic sat);
		offset_result_t e;
		if (pending.size() == 0) begin
			$error("result beat with nothing expected");
			errors++;
			return;
		end
		e = pending.pop_front();
		if (off !== e.off) begin
			$error("est_offset expected %0h actual %0h", e.off, off);
			errors++;
		end
		if (conf !== e.conf) begin
			$error("est_weight expected %0d actual %0d", e.conf, conf);
			errors++;
		end
		if (used !== e.used) begin
			$error("samples_used expected %0d actual %0d", e.used, used);
			errors++;
		end
		if (first !== e.first) begin
			$error("first_sample expected %0d actual %0d", e.first, first);
			errors++;
		end
		if (sat !== e.sat) begin
			$error("offset_saturated expected %0d actual %0d", e.sat, sat);
			errors++;
		end
	endfunction
endclass

module tb_top;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 0, in_ready;
	logic [3:0] exchange_id = '0;
	logic [62:0] venue_ts = '0, host_ts = '0;
	logic [39:0] rtt_ns = '0;
	logic out_valid, out_ready = 0;
	logic signed [47:0] est_offset;
	logic [16:0] est_weight;
	logic [4:0] samples_used;
	logic first_sample, offset_saturated;

	int send_idle = 22, recv_idle = 61;
	longint cycles = 0;
	offset_scoreboard board = new();

	always #5 clk = ~clk;

	exchange_clock_offset_estimator i_dut (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("exchange_clock_offset_estimator regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			board.check_result(est_offset, est_weight, samples_used,
				first_sample, offset_saturated);
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	task automatic write_window(logic [4:0] value);
		@(posedge clk);
		psel <= 1;
		pwrite <= 1;
		paddr <= {ceo_pkg::REG_WINDOW_LEN, 2'b00};
		pwdata <= {27'd0, value};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		board.window_len = value;
	endtask

	task automatic send_sample(logic [3:0] ex, logic [62:0] ext, logic [62:0] loc,
			logic [39:0] rtt);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		exchange_id <= ex;
		venue_ts <= ext;
		host_ts <= loc;
		rtt_ns <= rtt;
		do
			@(posedge clk);
		while (!in_ready);
		board.note_sample(ex, ext, loc, rtt);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (200)
			@(posedge clk);
	endtask

	task automatic random_sample();
		logic [62:0] base, loc;
		logic [39:0] rtt;
		base = 63'({$urandom, $urandom});
		case ($urandom_range(5))
			0: rtt = 40'({$urandom, $urandom});
			1: rtt = 40'($urandom_range(2000000000));
			default: rtt = 40'($urandom_range(200000000));
		endcase
		case ($urandom_range(4))
			0: loc = 63'({$urandom, $urandom});
			default: loc = base + 63'(rtt >> 1) + 63'($signed($urandom) >>> $urandom_range(31));
		endcase
		send_sample(4'($urandom_range(15)), base, loc, rtt);
	endtask

	initial begin
		repeat (7)
			@(posedge clk);
		arst_n <= 1;
		// directed: extremes, saturation both ways, weight floor, window wrap
		send_sample(4'd0, 63'd1000, 63'd5000, 40'd0);
		send_sample(4'd0, 63'd5000, 63'd1000, 40'd100);
		send_sample(4'd15, 63'd0, '1, 40'd0);
		send_sample(4'd15, '1, 63'd0, '1);
		send_sample(4'd15, '1, '1, 40'd999999999);
		send_sample(4'd1, 63'd0, 63'd0, 40'd900000000);
		send_sample(4'd1, 63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, 40'hAA_AAAA_AAAA);
		send_sample(4'd1, 63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555, 40'h55_5555_5555);
		for (int i = 0; i < 18; i++)
			send_sample(4'd2, 63'd100 * i, 63'd100 * i + 63'(i * 37), 40'(i * 60000000));
		drain();
		write_window(5'd1);
		for (int i = 0; i < 3; i++)
			send_sample(4'd2, 63'd10, 63'd20 + i, 40'd4);
		drain();
		write_window(5'd0);
		send_sample(4'd2, 63'd10, 63'd7, 40'd2);
		drain();
		write_window(5'd31);
		for (int i = 0; i < 160; i++)
			random_sample();
		drain();
		write_window(5'd3);
		send_idle = 61;
		recv_idle = 22;
		for (int i = 0; i < 160; i++)
			random_sample();
		drain();
		write_window(5'($urandom_range(1, 16)));
		send_idle = 0;
		recv_idle = 0;
		for (int i = 0; i < 180; i++)
			random_sample();
		drain();
		if (board.pending.size() == 0 && board.errors == 0)
			$display("exchange_clock_offset_estimator regression: pass");
		else
			$display("exchange_clock_offset_estimator regression: fail");
		$finish;
	end
endmodule

[files.f]
sv/ceo_pkg.sv
sv/ceo_front.sv
sv/ceo_fifo.sv
sv/ceo_back.sv
sv/exchange_clock_offset_estimator.sv
test/tb_top.sv
